// ----- rtl/gcov_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian covariance package
// Shared widths, constants and a rounding helper for the covariance pipeline.
// ----------------------------------------------------------------------------
package gcov_pkg;

   localparam int QW = 16;
   localparam int SW = 24;
   localparam int CW = 34;
   localparam int NLANE = 9;
   localparam int NELEM = 6;
   localparam int QBITS = 31;
   localparam int FRAC = 30;

   localparam logic signed [36:0] COV_MAX = 37'sd8589934591;
   localparam logic signed [36:0] COV_MIN = -37'sd8589934592;

   localparam int ROW_IDX [NELEM] = '{0, 0, 0, 1, 1, 2};
   localparam int COL_IDX [NELEM] = '{0, 1, 2, 1, 2, 2};

   // Shifts right, rounding to nearest with ties away from zero.
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int unsigned sh);
      logic        neg;
      logic [63:0] mag;
      neg = v[63];
      mag = neg ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

// ----- rtl/gaussian_covariance_from_quat_scale_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian covariance from quaternion and scale
// Normalizes a raw quaternion, builds the rotation and returns the upper
// triangle of R * diag(scale^2) * R^T in saturated signed 34-bit Q18.16.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while it is not stalled and
// passes it through squares, sums and operand setup, the bit-serial long
// division that forms the nine rotation entries, and products, rounding and
// summing. All stages stall together when the output register holds a result
// that is not taken. An all-zero quaternion is replaced by the identity and
// flagged in rsp_tuser.
module gaussian_covariance_from_quat_scale_top
   import gcov_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz, four zero bits
   output logic [207:0] rsp_tdata,
   // zero_orientation
   output logic [0:0]   rsp_tuser
);

   logic adv;

   // Stage 1: squares and cross products.
   logic               v1_ff, z1_ff;
   logic signed [31:0] w2_ff, x2_ff, y2_ff, z2_ff;
   logic signed [31:0] xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   logic [47:0]        ssq_ff [3];
   logic signed [15:0] qw_in, qx_in, qy_in, qz_in;
   logic               zero_in;

   // Stage 2: length, numerators, variances.
   logic               v2_ff, z2f_ff;
   logic [32:0]        len2_ff;
   logic signed [34:0] num_ff [NLANE];
   logic [32:0]        var2_ff [3];
   logic signed [35:0] len_s, num_in [NLANE];

   // Division pipeline, index 0 is the setup register.
   logic [32:0]        rem_ff [NLANE][QBITS+1];
   logic [30:0]        lo_ff  [NLANE][QBITS+1];
   logic [30:0]        quo_ff [NLANE][QBITS+1];
   logic               neg_ff [NLANE][QBITS+1];
   logic [32:0]        len_ff [QBITS+1];
   logic [32:0]        var_ff [QBITS+1][3];
   logic               dz_ff  [QBITS+1];
   logic               dv_ff  [QBITS+1];

   // Back end.
   logic signed [31:0] rot_ff [NLANE];
   logic signed [63:0] prod_ff [NELEM][3];
   logic signed [31:0] p_ff [NELEM][3];
   logic signed [63:0] pv_ff [NELEM][3];
   logic signed [34:0] t_ff [NELEM][3];
   logic [32:0]        tvar_ff [3][3];
   logic               tv_ff [5];
   logic               tz_ff [5];
   logic               out_valid_ff, out_zero_ff;
   logic signed [CW-1:0] cov_ff [NELEM];

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   assign qx_in   = req_tdata[31:16];
   assign qy_in   = req_tdata[47:32];
   assign qz_in   = req_tdata[63:48];
   assign zero_in = (req_tdata[63:0] == 64'd0);
   assign qw_in   = zero_in ? 16'sd1 : $signed(req_tdata[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
      if (adv) begin
         z1_ff  <= zero_in;
         w2_ff  <= qw_in * qw_in;
         x2_ff  <= qx_in * qx_in;
         y2_ff  <= qy_in * qy_in;
         z2_ff  <= qz_in * qz_in;
         xy_ff  <= qx_in * qy_in;
         zw_ff  <= qz_in * qw_in;
         xz_ff  <= qx_in * qz_in;
         yw_ff  <= qy_in * qw_in;
         yz_ff  <= qy_in * qz_in;
         xw_ff  <= qx_in * qw_in;
         for (int k = 0; k < 3; k++) begin
            ssq_ff[k] <= req_tdata[64+SW*k +: SW] * req_tdata[64+SW*k +: SW];
         end
      end
   end

   always_comb begin
      len_s     = 36'(w2_ff) + 36'(x2_ff) + 36'(y2_ff) + 36'(z2_ff);
      num_in[0] = len_s - 36'sd2 * (36'(y2_ff) + 36'(z2_ff));
      num_in[1] = 36'sd2 * (36'(xy_ff) - 36'(zw_ff));
      num_in[2] = 36'sd2 * (36'(xz_ff) + 36'(yw_ff));
      num_in[3] = 36'sd2 * (36'(xy_ff) + 36'(zw_ff));
      num_in[4] = len_s - 36'sd2 * (36'(x2_ff) + 36'(z2_ff));
      num_in[5] = 36'sd2 * (36'(yz_ff) - 36'(xw_ff));
      num_in[6] = 36'sd2 * (36'(xz_ff) - 36'(yw_ff));
      num_in[7] = 36'sd2 * (36'(yz_ff) + 36'(xw_ff));
      num_in[8] = len_s - 36'sd2 * (36'(x2_ff) + 36'(y2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         z2f_ff  <= z1_ff;
         len2_ff <= len_s[32:0];
         for (int l = 0; l < NLANE; l++) begin
            num_ff[l] <= num_in[l][34:0];
         end
         for (int k = 0; k < 3; k++) begin
            var2_ff[k] <= 33'((ssq_ff[k] + 48'd32768) >> 16);
         end
      end
   end

   // Division setup and side data.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v2_ff;
      end
      if (adv) begin
         len_ff[0] <= len2_ff;
         var_ff[0] <= var2_ff;
         dz_ff[0]  <= z2f_ff;
      end
   end

   genvar gl, gj;
   generate
      for (gl = 0; gl < NLANE; gl++) begin : g_lane
         logic [32:0] mag;
         logic [62:0] dvd;
         assign mag = num_ff[gl][34] ? 33'(-num_ff[gl]) : 33'(num_ff[gl]);
         assign dvd = ({30'd0, mag} << FRAC) + 63'(len2_ff >> 1);

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[gl][0] <= {1'b0, dvd[62:31]};
               lo_ff[gl][0]  <= dvd[30:0];
               quo_ff[gl][0] <= '0;
               neg_ff[gl][0] <= num_ff[gl][34];
            end
         end

         for (gj = 0; gj < QBITS; gj++) begin : g_step
            logic [33:0] trial;
            logic        ge;
            assign trial = {rem_ff[gl][gj], lo_ff[gl][gj][QBITS-1-gj]};
            assign ge    = trial >= {1'b0, len_ff[gj]};
            always_ff @(posedge clock) begin
               if (adv) begin
                  rem_ff[gl][gj+1] <= ge ? 33'(trial - {1'b0, len_ff[gj]}) : trial[32:0];
                  lo_ff[gl][gj+1]  <= lo_ff[gl][gj];
                  quo_ff[gl][gj+1] <= {quo_ff[gl][gj][29:0], ge};
                  neg_ff[gl][gj+1] <= neg_ff[gl][gj];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rot_ff[gl] <= neg_ff[gl][QBITS] ? -$signed({1'b0, quo_ff[gl][QBITS]})
                                               : $signed({1'b0, quo_ff[gl][QBITS]});
            end
         end
      end

      for (gj = 0; gj < QBITS; gj++) begin : g_side
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[gj+1] <= 1'b0;
            end else if (adv) begin
               dv_ff[gj+1] <= dv_ff[gj];
            end
            if (adv) begin
               len_ff[gj+1] <= len_ff[gj];
               var_ff[gj+1] <= var_ff[gj];
               dz_ff[gj+1]  <= dz_ff[gj];
            end
         end
      end
   endgenerate

   // Back-end valid and side data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 5; s++) begin
            tv_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         tv_ff[0] <= dv_ff[QBITS];
         for (int s = 1; s < 5; s++) begin
            tv_ff[s] <= tv_ff[s-1];
         end
      end
      if (adv) begin
         tz_ff[0]   <= dz_ff[QBITS];
         tvar_ff[0] <= var_ff[QBITS];
         for (int s = 1; s < 5; s++) begin
            tz_ff[s] <= tz_ff[s-1];
         end
         for (int s = 1; s < 3; s++) begin
            tvar_ff[s] <= tvar_ff[s-1];
         end
      end
   end

   genvar ge_, gk;
   generate
      for (ge_ = 0; ge_ < NELEM; ge_++) begin : g_elem
         logic signed [36:0] sum;
         for (gk = 0; gk < 3; gk++) begin : g_term
            always_ff @(posedge clock) begin
               if (adv) begin
                  prod_ff[ge_][gk] <= rot_ff[ROW_IDX[ge_]*3+gk] * rot_ff[COL_IDX[ge_]*3+gk];
                  p_ff[ge_][gk]    <= 32'(rnd_shr(prod_ff[ge_][gk], FRAC));
                  pv_ff[ge_][gk]   <= p_ff[ge_][gk] * $signed({1'b0, tvar_ff[2][gk]});
                  t_ff[ge_][gk]    <= 35'(rnd_shr(pv_ff[ge_][gk], FRAC));
               end
            end
         end
         assign sum = 37'(t_ff[ge_][0]) + 37'(t_ff[ge_][1]) + 37'(t_ff[ge_][2]);
         always_ff @(posedge clock) begin
            if (adv) begin
               priority if (sum > COV_MAX) begin
                  cov_ff[ge_] <= COV_MAX[CW-1:0];
               end else if (sum < COV_MIN) begin
                  cov_ff[ge_] <= COV_MIN[CW-1:0];
               end else begin
                  cov_ff[ge_] <= sum[CW-1:0];
               end
            end
         end
         assign rsp_tdata[CW*ge_ +: CW] = cov_ff[ge_];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= tv_ff[4];
      end
      if (adv) begin
         out_zero_ff <= tz_ff[4];
      end
   end

   assign rsp_tdata[207:204] = 4'd0;
   assign rsp_tvalid         = out_valid_ff;
   assign rsp_tuser          = out_zero_ff;

   // The identity fallback gives a diagonal covariance.
   a_zero_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> cov_ff[1] == '0 && cov_ff[2] == '0 && cov_ff[4] == '0)
      else $error("identity fallback produced off-diagonal terms");

   // Diagonal elements are sums of squares times variances.
   a_diag_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !cov_ff[0][CW-1] && !cov_ff[3][CW-1] && !cov_ff[5][CW-1])
      else $error("negative diagonal covariance");

   // Reset leaves no transaction in flight.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // The first rotation entry never exceeds one in magnitude.
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QBITS] |-> quo_ff[0][QBITS] <= 31'h4000_0000)
      else $error("rotation entry out of range");

endmodule

// ----- dv/gaussian_covariance_from_quat_scale_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian covariance block testbench
// Streams quaternion and scale transactions into the covariance block under
// random idling on both sides and a long output hold-off. Each result is
// checked field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module gaussian_covariance_from_quat_scale_top_test;
   import gcov_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [CW-1:0] cov [NELEM];
      logic          zero_quat;
   } cov_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   cov_result_type pending_cov [$];
   int          mismatches = 0;
   int          sent_count = 0;
   int          recv_count = 0;
   int          zero_seen = 0;
   int          idle_cycles = 0;
   int          hold_cycles = 0;
   bit          send_gaps = 1'b1;
   bit          recv_gaps = 1'b1;

   gaussian_covariance_from_quat_scale_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic longint round_shr(longint v, int sh);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint rot_q30(longint n, longint d);
      longint unsigned m;
      longint unsigned q;
      m = (n < 0) ? longint'(-n) : n;
      q = ((m << 30) + (longint'(d) >> 1)) / d;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic cov_result_type predict_cov(logic [135:0] d);
      cov_result_type r;
      longint w, x, y, z, len, s, sum, p;
      longint var_k [3];
      longint nm [3][3];
      longint rot [3][3];
      int ri, ci;
      w = longint'($signed(d[15:0]));
      x = longint'($signed(d[31:16]));
      y = longint'($signed(d[47:32]));
      z = longint'($signed(d[63:48]));
      r.zero_quat = (w == 0 && x == 0 && y == 0 && z == 0);
      if (r.zero_quat) w = 1;
      len = w * w + x * x + y * y + z * z;
      for (int k = 0; k < 3; k++) begin
         s = longint'(d[64 + 24 * k +: 24]);
         var_k[k] = round_shr(s * s, 16);
      end
      nm[0][0] = len - 2 * (y * y + z * z);
      nm[0][1] = 2 * (x * y - z * w);
      nm[0][2] = 2 * (x * z + y * w);
      nm[1][0] = 2 * (x * y + z * w);
      nm[1][1] = len - 2 * (x * x + z * z);
      nm[1][2] = 2 * (y * z - x * w);
      nm[2][0] = 2 * (x * z - y * w);
      nm[2][1] = 2 * (y * z + x * w);
      nm[2][2] = len - 2 * (x * x + y * y);
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            rot[i][k] = rot_q30(nm[i][k], len);
      for (int e = 0; e < NELEM; e++) begin
         ri = ROW_IDX[e];
         ci = COL_IDX[e];
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            p = round_shr(rot[ri][k] * rot[ci][k], 30);
            sum += round_shr(p * var_k[k], 30);
         end
         if (sum > 64'sd8589934591) sum = 64'sd8589934591;
         if (sum < -64'sd8589934592) sum = -64'sd8589934592;
         r.cov[e] = sum[CW-1:0];
      end
      return r;
   endfunction

   function automatic logic [135:0] pack_item(logic [15:0] qw, logic [15:0] qx,
                                              logic [15:0] qy, logic [15:0] qz,
                                              logic [23:0] sx, logic [23:0] sy,
                                              logic [23:0] sz);
      return {sz, sy, sx, qz, qy, qx, qw};
   endfunction

   task automatic report_mismatch(string field, logic [CW-1:0] got, logic [CW-1:0] want);
      mismatches++;
      if (mismatches <= 20)
         $display("ERROR %0t: %s got %h expected %h", $realtime, field, got, want);
   endtask

   task automatic send_item(logic [135:0] d);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      pending_cov.insert(pending_cov.size(), predict_cov(d));
      sent_count++;
   endtask

   function automatic logic [15:0] rand_quat_part(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 8)) - 4);
         default: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      endcase
   endfunction

   function automatic logic [135:0] rand_item();
      int qm;
      logic [23:0] sc [3];
      qm = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++)
         case ($urandom_range(0, 7))
            0: sc[k] = 24'h0;
            1: sc[k] = 24'hffffff;
            2: sc[k] = 24'($urandom_range(0, 255));
            default: sc[k] = 24'($urandom);
         endcase
      if (qm == 0)
         return pack_item(16'h0, 16'h0, 16'h0, 16'h0, sc[0], sc[1], sc[2]);
      qm = (qm < 7) ? 0 : (qm < 9) ? 1 : 2;
      return pack_item(rand_quat_part(qm), rand_quat_part(qm), rand_quat_part(qm),
                       rand_quat_part(qm), sc[0], sc[1], sc[2]);
   endfunction

   task automatic test_directed();
      send_item(pack_item(16'h0, 16'h0, 16'h0, 16'h0, 24'h010000, 24'h020000, 24'h030000));
      send_item(pack_item(16'h0, 16'h0, 16'h0, 16'h0, 24'hffffff, 24'hffffff, 24'hffffff));
      send_item(pack_item(16'h0001, 16'h0, 16'h0, 16'h0, 24'h0, 24'h0, 24'h0));
      send_item(pack_item(16'h7fff, 16'h0, 16'h0, 16'h0, 24'hffffff, 24'h0, 24'h000001));
      send_item(pack_item(16'h8000, 16'h0, 16'h0, 16'h0, 24'h018000, 24'h008000, 24'h0));
      send_item(pack_item(16'h0, 16'h0001, 16'h0, 16'h0, 24'h010000, 24'h020000, 24'h040000));
      send_item(pack_item(16'h0, 16'h0, 16'h8000, 16'h0, 24'h010000, 24'h020000, 24'h040000));
      send_item(pack_item(16'h0, 16'h0, 16'h0, 16'h7fff, 24'h010000, 24'h020000, 24'h040000));
      send_item(pack_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          24'hffffff, 24'hffffff, 24'hffffff));
      send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          24'hffffff, 24'h0, 24'hffffff));
      send_item(pack_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                          24'hffffff, 24'h000001, 24'h0));
      send_item(pack_item(16'h0001, 16'h0001, 16'h0, 16'h0, 24'h0, 24'hffffff, 24'h0));
      send_item(pack_item(16'hffff, 16'h0, 16'h0001, 16'h0, 24'hffffff, 24'h0, 24'h0));
      send_item(pack_item(16'h0003, 16'hfffe, 16'h0001, 16'hffff,
                          24'h123456, 24'h789abc, 24'hfedcba));
      send_item(pack_item(16'h0, 16'h5555, 16'haaaa, 16'h0, 24'h555555, 24'haaaaaa, 24'h0));
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_item(rand_item());
   endtask

   task automatic test_output_hold();
      hold_cycles = 300;
      for (int i = 0; i < 120; i++) send_item(rand_item());
   endtask

   task automatic test_streaming(int n);
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      for (int i = 0; i < n; i++) send_item(rand_item());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1500);
      test_output_hold();
      test_streaming(320);
      req_tvalid <= 1'b0;
      while (pending_cov.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions and checked %0d results (%0d zero quaternions),",
               sent_count, recv_count, zero_seen);
      $display("including directed extremes, random idling and a long output hold-off.");
      if (mismatches == 0 && pending_cov.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      int stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else if (!recv_gaps) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
      end
   end

   always @(posedge clock) begin
      cov_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         recv_count++;
         if (pending_cov.size() == 0) begin
            mismatches++;
            $display("ERROR %0t: result transaction with nothing expected", $realtime);
         end else begin
            want = pending_cov.pop_front();
            for (int e = 0; e < NELEM; e++)
               if (rsp_tdata[e * CW +: CW] !== want.cov[e])
                  report_mismatch($sformatf("cov element %0d", e),
                                  rsp_tdata[e * CW +: CW], want.cov[e]);
            if (rsp_tdata[207:204] !== 4'h0)
               report_mismatch("padding", CW'(rsp_tdata[207:204]), '0);
            if (rsp_tuser[0] !== want.zero_quat)
               report_mismatch("zero_orientation", CW'(rsp_tuser[0]), CW'(want.zero_quat));
            if (want.zero_quat) zero_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR %0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
